// ===== rtl/first_derivative_stencil_8th_defines.svh =====
// assertion macros for the first derivative stencil block
`ifndef FIRST_DERIVATIVE_STENCIL_8TH_DEFINES_SVH
`define FIRST_DERIVATIVE_STENCIL_8TH_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FDS_ASSERT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FDS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fds_pkg.sv =====
// shared constants and types for the first derivative stencil block
`timescale 1ns / 1ps
package fds_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int WIN_DEPTH        = 9;
  localparam int NUM_TAPS         = 4;
  localparam int COEF_WIDTH       = 18;
  localparam int DERIV_WIDTH      = 32;
  localparam int CFG_WIDTH        = 32;

  // q1.17 antisymmetric stencil weights, nearest neighbor first
  localparam logic signed [COEF_WIDTH-1:0] STENCIL_COEF [NUM_TAPS] = '{
    18'sd110065, -18'sd31879, 18'sd7810, -18'sd1058
  };

  localparam logic [CFG_WIDTH-1:0] INV_SPACING_RESET = 32'd65536;

  // sequence position thresholds on the count taken before the current sample
  localparam logic [3:0] COUNT_MAX      = 4'd15;
  localparam logic [3:0] EDGE_START     = 4'd4;
  localparam logic [3:0] INTERIOR_START = 4'd8;
  localparam logic [3:0] MIN_LEN_M1     = 4'd7;

  // end-of-sequence burst issues steps 0 to this one
  localparam logic [2:0] BURST_LAST_STEP = 3'd4;
  localparam logic [1:0] TAP_NEAREST     = 2'd3;

  typedef struct packed {
    logic valid;
    logic last;
    logic too_short;
  } fds_tag_t;

endpackage

// ===== rtl/first_derivative_stencil_8th.sv =====
// a transferred sample's first result passes the stencil and scaler registers to the output
// throughput: one sample, or one result, per cycle unless stalled; a closing sample of a run
//   of 8 or more issues 5 results on the shared stencil pipeline and holds input to the last
// output back-pressure freezes the whole pipeline, issue stage and input included
// reset (rst, synchronous): count, issue state and valid bits clear, spacing = 1.0
`timescale 1ns / 1ps
`include "first_derivative_stencil_8th_defines.svh"
module first_derivative_stencil_8th import fds_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // input stream
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,  // sample, zero pad
  input  logic                                    s_axis_tlast,  // last_sample
  // result stream
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [DERIV_WIDTH-1:0]                  m_axis_tdata,  // derivative
  output logic                                    m_axis_tlast,  // last_result
  output logic                                    m_axis_tuser,  // too_short
  // configuration write
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [CFG_WIDTH-1:0]                    cfg_data       // inv_spacing
);

  localparam int SW = SAMPLE_WIDTH;

  logic                 en;
  logic                 in_fire;
  logic [CFG_WIDTH-1:0] inv_spacing;
  logic [3:0]           samples_seen;

  // issue stage: which result(s) the last accepted sample still owes
  logic       iss_active;
  logic       iss_burst;
  logic       iss_first_int;
  logic       iss_short;
  logic [2:0] iss_step;
  logic       iss_final;

  logic signed [SW-1:0] win [WIN_DEPTH];
  logic                 sel_interior;
  logic [1:0]           sel_tap;
  fds_tag_t             iss_tag;
  logic signed [SW+1:0] d_q16;
  fds_tag_t             d_tag;
  fds_tag_t             out_tag;

  // the pipeline only stalls when a finished result is not taken
  assign en            = !(m_axis_tvalid && !m_axis_tready);
  assign iss_final     = !iss_burst || (iss_step == BURST_LAST_STEP);
  assign s_axis_tready = en && (!iss_active || iss_final);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_spacing <= INV_SPACING_RESET;
    end else if (cfg_valid) begin
      inv_spacing <= cfg_data;
    end
  end

  // window: nine cells, newest in cell 0, shifted by each input transfer
  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_win
    if (k == 0) begin : g_head
      fds_cell #(.W(SW)) u_cell (
        .clk  (clk),
        .en   (in_fire),
        .din  (s_axis_tdata[SW-1:0]),
        .dout (win[k])
      );
    end else begin : g_body
      fds_cell #(.W(SW)) u_cell (
        .clk  (clk),
        .en   (in_fire),
        .din  (win[k-1]),
        .dout (win[k])
      );
    end
  end

  // position in the sequence, saturating; restarts after a last transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen <= '0;
    end else if (in_fire) begin
      if (s_axis_tlast) begin
        samples_seen <= '0;
      end else if (samples_seen != COUNT_MAX) begin
        samples_seen <= samples_seen + 4'd1;
      end
    end
  end

  // issue sequencing
  // non-last sample: one result from the fifth sample on (edge, then interior)
  // last sample of a short sequence: one flagged zero result
  // last sample otherwise: centered or edge result, then four backward differences
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_active    <= 1'b0;
      iss_burst     <= 1'b0;
      iss_first_int <= 1'b0;
      iss_short     <= 1'b0;
      iss_step      <= '0;
    end else if (en) begin
      if (in_fire) begin
        iss_step      <= '0;
        iss_first_int <= (samples_seen >= INTERIOR_START);
        if (s_axis_tlast) begin
          iss_active <= 1'b1;
          iss_short  <= (samples_seen < MIN_LEN_M1);
          iss_burst  <= (samples_seen >= MIN_LEN_M1);
        end else begin
          iss_active <= (samples_seen >= EDGE_START);
          iss_short  <= 1'b0;
          iss_burst  <= 1'b0;
        end
      end else if (iss_active && iss_final) begin
        iss_active <= 1'b0;
      end else if (iss_active) begin
        iss_step <= iss_step + 3'd1;
      end
    end
  end

  // step 0 takes the nearest difference, later steps walk toward the newest sample
  always_comb begin
    sel_interior      = iss_first_int && (iss_step == '0);
    sel_tap           = (iss_step == '0) ? TAP_NEAREST : 2'(BURST_LAST_STEP - iss_step);
    iss_tag.valid     = iss_active;
    iss_tag.too_short = iss_short;
    iss_tag.last      = iss_short || (iss_burst && (iss_step == BURST_LAST_STEP));
  end

  fds_stencil #(.SAMPLE_WIDTH(SW)) u_stencil (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .win          (win),
    .sel_interior (sel_interior),
    .sel_tap      (sel_tap),
    .tag_in       (iss_tag),
    .d_out        (d_q16),
    .tag_out      (d_tag)
  );

  // last stage of the scaler is the output register
  fds_scale #(.SAMPLE_WIDTH(SW)) u_scale (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .d_in        (d_q16),
    .tag_in      (d_tag),
    .inv_spacing (inv_spacing),
    .deriv       (m_axis_tdata),
    .tag_out     (out_tag)
  );

  assign m_axis_tvalid = out_tag.valid;
  assign m_axis_tlast  = out_tag.last;
  assign m_axis_tuser  = out_tag.too_short;

  `FDS_ASSERT_NEXT(a_last_clears_count, clk, rst, in_fire && s_axis_tlast, samples_seen == '0, "count not cleared after last transfer")
  `FDS_ASSERT(a_short_is_zero_last, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == '0), "short-sequence result malformed")
  `FDS_ASSERT(a_burst_holds_input, clk, rst, iss_active && !iss_final, !s_axis_tready, "input taken during end-of-sequence burst")
  `FDS_ASSERT(a_step_in_range, clk, rst, iss_active, iss_step <= BURST_LAST_STEP, "issue step out of range")

endmodule

// ===== rtl/fds_cell.sv =====
// one sample cell of the window chain
`timescale 1ns / 1ps
module fds_cell #(
  parameter int W = 24
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= din;
    end
  end

endmodule

// ===== rtl/fds_stencil.sv =====
// stencil products and rounded q.16 difference, two pipeline stages
`timescale 1ns / 1ps
module fds_stencil import fds_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic signed [SAMPLE_WIDTH-1:0] win [WIN_DEPTH],
  input  logic                           sel_interior,
  input  logic [1:0]                     sel_tap,
  input  fds_tag_t                       tag_in,
  output logic signed [SAMPLE_WIDTH+1:0] d_out,
  output fds_tag_t                       tag_out
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int EW   = SW + 1;
  localparam int PW   = EW + COEF_WIDTH;
  localparam int SUMW = PW + 2;
  localparam int DW   = SW + 2;

  logic signed [EW-1:0]   cdiff [NUM_TAPS];
  logic signed [EW-1:0]   ediff [NUM_TAPS];
  logic signed [PW-1:0]   prod_next [NUM_TAPS];
  logic signed [PW-1:0]   prod [NUM_TAPS];
  logic signed [EW-1:0]   edge_diff;
  logic                   interior;
  fds_tag_t               tag1;
  logic signed [SUMW-1:0] sum;
  logic signed [DW-1:0]   d_next;

  // stage 1: tap differences and products
  always_comb begin
    for (int t = 0; t < NUM_TAPS; t++) begin
      cdiff[t]     = EW'(win[3-t]) - EW'(win[5+t]);
      ediff[t]     = EW'(win[t]) - EW'(win[t+1]);
      prod_next[t] = PW'(cdiff[t]) * PW'(STENCIL_COEF[t]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod      <= prod_next;
      edge_diff <= ediff[sel_tap];
      interior  <= sel_interior;
    end
  end

  // stage 2: sum, round half up to q.16
  always_comb begin
    sum = SUMW'(prod[0]) + SUMW'(prod[1]) + SUMW'(prod[2]) + SUMW'(prod[3])
          + SUMW'(65536);
    if (tag1.too_short) begin
      d_next = '0;
    end else if (interior) begin
      d_next = sum[DW+16:17];
    end else begin
      d_next = DW'(edge_diff);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1    <= '0;
      tag_out <= '0;
    end else if (en) begin
      tag1    <= tag_in;
      tag_out <= tag1;
    end
  end

endmodule

// ===== rtl/fds_scale.sv =====
// scale by reciprocal spacing, round and saturate, two pipeline stages
`timescale 1ns / 1ps
module fds_scale import fds_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic signed [SAMPLE_WIDTH+1:0] d_in,
  input  fds_tag_t                       tag_in,
  input  logic [CFG_WIDTH-1:0]           inv_spacing,
  output logic [DERIV_WIDTH-1:0]         deriv,
  output fds_tag_t                       tag_out
);

  localparam int DW = SAMPLE_WIDTH + 2;
  localparam int MW = DW + 17;
  localparam int RW = (MW + 1 > DERIV_WIDTH + 1) ? MW + 1 : DERIV_WIDTH + 1;
  localparam logic signed [RW-1:0] SAT_MAX = RW'(64'sd2147483647);
  localparam logic signed [RW-1:0] SAT_MIN = RW'(-64'sd2147483648);

  logic signed [16:0]   hi_s;
  logic signed [16:0]   lo_s;
  logic signed [MW-1:0] mh_next;
  logic signed [MW-1:0] ml_next;
  logic signed [MW-1:0] mh;
  logic signed [MW-1:0] ml;
  fds_tag_t             tag3;
  logic signed [MW:0]   lo_sum;
  logic signed [RW-1:0] r;
  logic [DERIV_WIDTH-1:0] deriv_next;

  // stage 3: integer and fraction parts of the reciprocal, one multiply each
  always_comb begin
    hi_s    = $signed({1'b0, inv_spacing[31:16]});
    lo_s    = $signed({1'b0, inv_spacing[15:0]});
    mh_next = MW'(d_in) * MW'(hi_s);
    ml_next = MW'(d_in) * MW'(lo_s);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mh <= mh_next;
      ml <= ml_next;
    end
  end

  // stage 4: round the fraction product, add, clamp to 32 bits
  always_comb begin
    lo_sum = (MW+1)'(ml) + (MW+1)'(32768);
    r      = RW'(mh) + RW'($signed(lo_sum[MW:16]));
    if (r > SAT_MAX) begin
      deriv_next = SAT_MAX[DERIV_WIDTH-1:0];
    end else if (r < SAT_MIN) begin
      deriv_next = SAT_MIN[DERIV_WIDTH-1:0];
    end else begin
      deriv_next = r[DERIV_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deriv <= deriv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag3    <= '0;
      tag_out <= '0;
    end else if (en) begin
      tag3    <= tag_in;
      tag_out <= tag3;
    end
  end

endmodule

// ===== tb/first_derivative_stencil_8th_tb.sv =====
// self-checking testbench for the eighth-order first derivative stencil stream
`timescale 1ns / 1ps
module first_derivative_stencil_8th_tb;
  import fds_pkg::*;

  localparam int SW              = SAMPLE_WIDTH_DEF;
  localparam int TDATA_W         = ((SW + 7) / 8) * 8;
  localparam int QUIET_LIMIT     = 3000;
  localparam int ITEMS_PER_PHASE = 32;
  localparam int NUM_PHASES      = 8;
  localparam int SETTLE_CYCLES   = 12;

  // q1.17 weights of the central stencil, nearest neighbor first
  localparam longint TAP_WEIGHT [4] = '{110065, -31879, 7810, -1058};
  localparam longint DERIV_MAX = 64'sd2147483647;
  localparam longint DERIV_MIN = -64'sd2147483648;

  typedef struct {
    logic [DERIV_WIDTH-1:0] deriv;
    logic                   end_mark;
    logic                   short_seq;
  } deriv_result_t;

  // predicts derivatives from accepted samples and checks the output stream
  class deriv_scoreboard;
    longint          win [WIN_DEPTH];
    int unsigned     seen;
    logic [31:0]     spacing;
    deriv_result_t   expected_q [$];
    int              errors;

    function new();
      foreach (win[i]) win[i] = 0;
      seen    = 0;
      spacing = INV_SPACING_RESET;
      errors  = 0;
    endfunction

    function void set_spacing(logic [31:0] v);
      spacing = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // q.16 value times q16.16 spacing, round half up, saturate
    function logic [DERIV_WIDTH-1:0] scale(longint d);
      longint hi;
      longint lo;
      longint r;
      hi = spacing[31:16];
      lo = spacing[15:0];
      r  = d * hi + ((d * lo + 32768) >>> 16);
      if (r > DERIV_MAX) r = DERIV_MAX;
      else if (r < DERIV_MIN) r = DERIV_MIN;
      return r[DERIV_WIDTH-1:0];
    endfunction

    // nine-point stencil centered on window slot 4, back to q.16
    function longint central();
      longint acc;
      acc = 0;
      for (int t = 0; t < 4; t++) acc += TAP_WEIGHT[t] * (win[3 - t] - win[5 + t]);
      return (acc + 65536) >>> 17;
    endfunction

    function void push(logic [DERIV_WIDTH-1:0] d, logic e, logic s);
      deriv_result_t r;
      r.deriv     = d;
      r.end_mark  = e;
      r.short_seq = s;
      expected_q.push_back(r);
    endfunction

    function void note_sample(logic [SW-1:0] smp, logic closing);
      int unsigned c;
      longint      d;
      c = seen;
      for (int t = WIN_DEPTH - 1; t > 0; t--) win[t] = win[t - 1];
      win[0] = longint'($signed(smp));
      if (!closing) begin
        if (c >= EDGE_START) begin
          d = (c < INTERIOR_START) ? (win[3] - win[4]) : central();
          push(scale(d), 1'b0, 1'b0);
        end
        if (c < COUNT_MAX) seen = c + 1;
      end else begin
        seen = 0;
        if (c < MIN_LEN_M1) begin
          // too short: a single flagged zero result closes the sequence
          push('0, 1'b1, 1'b1);
        end else begin
          d = (c >= INTERIOR_START) ? central() : (win[3] - win[4]);
          push(scale(d), 1'b0, 1'b0);
          // backward differences for the last four points
          for (int t = 3; t >= 0; t--) push(scale(win[t] - win[t + 1]), t == 0, 1'b0);
        end
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [DERIV_WIDTH-1:0] d, logic e, logic s);
      deriv_result_t x;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h with nothing expected", d));
        return;
      end
      x = expected_q.pop_front();
      if (d !== x.deriv) report($sformatf("derivative %h, expected %h", d, x.deriv));
      if (e !== x.end_mark) report($sformatf("last_result %b, expected %b", e, x.end_mark));
      if (s !== x.short_seq) report($sformatf("too_short %b, expected %b", s, x.short_seq));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_W-1:0]     s_axis_tdata = '0;   // sample
  logic                   s_axis_tlast = 1'b0; // last_sample
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [DERIV_WIDTH-1:0] m_axis_tdata;        // derivative
  logic                   m_axis_tlast;        // last_result
  logic                   m_axis_tuser;        // too_short
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_WIDTH-1:0]   cfg_data = '0;       // inv_spacing

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int phase_items;

  deriv_scoreboard sb = new();

  first_derivative_stencil_8th #(
    .SAMPLE_WIDTH(SW)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // result side: random back-pressure and checking of every transfer
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL first_derivative_stencil_8th");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one sample transfer; tvalid stays high on return so back-to-back items need no gap
  task automatic send_item(logic [SW-1:0] smp, logic closing);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= closing;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_sample(smp, closing);
    phase_items++;
  endtask

  function automatic logic [SW-1:0] random_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return SW'($urandom);
    if (pick < 80) return SW'(int'($urandom_range(1023)) - 512);
    case ($urandom_range(3))
      0:       return {1'b0, {(SW-1){1'b1}}};
      1:       return {1'b1, {(SW-1){1'b0}}};
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  task automatic send_sequence(int len);
    for (int i = 0; i < len; i++) send_item(random_sample(), i == len - 1);
  endtask

  // sender holds off until every expected result is back, then lets the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_spacing(logic [CFG_WIDTH-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_spacing(v);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CFG_WIDTH-1:0] spacing_plan [NUM_PHASES];
    int                   pick;
    spacing_plan = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, $urandom,
                     32'h0000_8000, $urandom, 32'h8000_0000, 32'h0003_4000};
    phase_items = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_spacing(INV_SPACING_RESET);

    // directed: lone closing sample, short run with released forward results,
    // minimum full length at the extremes, and one interior point at the close
    send_item('0, 1'b1);
    send_item({1'b0, {(SW-1){1'b1}}}, 1'b0);
    send_item({1'b1, {(SW-1){1'b0}}}, 1'b0);
    send_item('0, 1'b0);
    send_item('1, 1'b0);
    send_item(24'sd1, 1'b0);
    send_item({1'b0, {(SW-1){1'b1}}}, 1'b0);
    send_item({1'b1, {(SW-1){1'b0}}}, 1'b1);
    for (int i = 0; i < 8; i++)
      send_item(i[0] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}}, i == 7);
    for (int i = 0; i < 9; i++) send_item(SW'(i * 70000 - 300000), i == 8);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_spacing(spacing_plan[p]);
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 10) send_sequence($urandom_range(1, 7));
        else if (pick < 85) send_sequence($urandom_range(8, 20));
        else send_sequence($urandom_range(21, 40));
      end
    end

    // a missing result keeps drain waiting and trips the watchdog
    drain();
    if (sb.errors == 0) begin
      $display("PASS first_derivative_stencil_8th");
    end else begin
      $display("FAIL first_derivative_stencil_8th");
    end
    $finish;
  end

endmodule
